// File: src/itri_pkg.sv
package itri_pkg;

  localparam int NUM_CTR = 3;

  // request types
  localparam logic [2:0] REQ_READ   = 3'd0;
  localparam logic [2:0] REQ_WRITE  = 3'd1;
  localparam logic [2:0] REQ_EXPIRY = 3'd2;
  localparam logic [2:0] REQ_START  = 3'd3;
  localparam logic [2:0] REQ_STOP   = 3'd4;

  // register map
  localparam logic [2:0] REG_CONTROL = 3'd3;
  localparam logic [2:0] REG_CLR_CLK = 3'd4;

  // counters
  localparam logic [1:0] CTR_SANITY   = 2'd0;
  localparam logic [1:0] CTR_INTERVAL = 2'd1;
  localparam logic [1:0] CTR_BUS      = 2'd2;

  // access modes, control bits 5:4
  localparam logic [1:0] MODE_LSB  = 2'd1;
  localparam logic [1:0] MODE_MSB  = 2'd2;
  localparam logic [1:0] MODE_WORD = 2'd3;

  // control select field value that marks a read-back command
  localparam logic [1:0] SEL_READBACK = 2'd3;

  // clock interrupt actions
  localparam logic [1:0] CLK_NONE  = 2'd0;
  localparam logic [1:0] CLK_SET   = 2'd1;
  localparam logic [1:0] CLK_CLEAR = 2'd2;

  localparam logic [15:0] COUNT_FULL = 16'hffff;

  typedef struct packed {
    logic [2:0] req_type;
    logic [2:0] reg_select;
    logic [7:0] write_data;
    logic [1:0] counter_sel;
    logic [2:0] inhibit;     // bit n inhibits counter n
  } req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        start_valid;
    logic [1:0]  start_counter;
    logic [15:0] start_delay;
    logic        stop_valid;
    logic        nmi_raise;
    logic        sanity_timeout_set;
    logic        bus_timeout_set;
    logic        bus_timeout_irq;
    logic [1:0]  clock_irq_action;
    logic        bus_abort;
  } result_t;

endpackage

// File: src/itri_ctr_bank.sv
module itri_ctr_bank (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  itri_pkg::req_t  req,
  output itri_pkg::result_t res
);
  import itri_pkg::*;

  logic [7:0]  ctrl        [NUM_CTR];
  logic [15:0] divider     [NUM_CTR];
  logic [15:0] count       [NUM_CTR];
  logic        enabled     [NUM_CTR];
  logic        write_high  [NUM_CTR];
  logic        read_high   [NUM_CTR];
  logic        stat_valid  [NUM_CTR];
  logic        cnt_valid   [NUM_CTR];
  logic [7:0]  stat_latch  [NUM_CTR];
  logic [15:0] cnt_snap    [NUM_CTR];

  logic [7:0]  ctrl_next       [NUM_CTR];
  logic [15:0] divider_next    [NUM_CTR];
  logic [15:0] count_next      [NUM_CTR];
  logic        enabled_next    [NUM_CTR];
  logic        write_high_next [NUM_CTR];
  logic        read_high_next  [NUM_CTR];
  logic        stat_valid_next [NUM_CTR];
  logic        cnt_valid_next  [NUM_CTR];
  logic [7:0]  stat_latch_next [NUM_CTR];
  logic [15:0] cnt_snap_next   [NUM_CTR];

  logic [7:0]  lane_rd     [NUM_CTR];
  logic        lane_start  [NUM_CTR];
  logic [15:0] lane_delay  [NUM_CTR];
  logic        lane_nmi    [NUM_CTR];
  logic        lane_btset  [NUM_CTR];
  logic        lane_btirq  [NUM_CTR];
  logic        lane_clk    [NUM_CTR];
  logic        lane_abort  [NUM_CTR];

  for (genvar i = 0; i < NUM_CTR; i++) begin : g_lane
    localparam logic [1:0]  IDX  = 2'(i);
    localparam logic [15:0] SUB  = (i == 2) ? 16'd2 : 16'd0;
    localparam logic [15:0] STEP = (i == 2) ? 16'd2 : 16'd1;

    always_comb begin
      logic [1:0] mode;
      logic       load;
      logic       data_hit;
      logic       sel_hit;
      mode     = ctrl[i][5:4];
      load     = 1'b0;
      data_hit = (req.reg_select == {1'b0, IDX});
      sel_hit  = (req.counter_sel == IDX);

      ctrl_next[i]       = ctrl[i];
      divider_next[i]    = divider[i];
      count_next[i]      = count[i];
      enabled_next[i]    = enabled[i];
      write_high_next[i] = write_high[i];
      read_high_next[i]  = read_high[i];
      stat_valid_next[i] = stat_valid[i];
      cnt_valid_next[i]  = cnt_valid[i];
      stat_latch_next[i] = stat_latch[i];
      cnt_snap_next[i]   = cnt_snap[i];

      lane_rd[i]    = '0;
      lane_start[i] = 1'b0;
      lane_delay[i] = '0;
      lane_nmi[i]   = 1'b0;
      lane_btset[i] = 1'b0;
      lane_btirq[i] = 1'b0;
      lane_clk[i]   = 1'b0;
      lane_abort[i] = 1'b0;

      case (req.req_type)
        REQ_READ: begin
          if (data_hit) begin
            case (mode)
              MODE_LSB: lane_rd[i] = count[i][7:0];
              MODE_MSB: lane_rd[i] = count[i][15:8];
              MODE_WORD: begin
                if (stat_valid[i]) begin
                  stat_valid_next[i] = 1'b0;
                  lane_rd[i]         = stat_latch[i];
                end else if (cnt_valid[i]) begin
                  if (read_high[i]) begin
                    read_high_next[i] = 1'b0;
                    cnt_valid_next[i] = 1'b0;
                    lane_rd[i]        = cnt_snap[i][15:8];
                  end else begin
                    read_high_next[i] = 1'b1;
                    lane_rd[i]        = cnt_snap[i][7:0];
                  end
                end else if (read_high[i]) begin
                  read_high_next[i] = 1'b0;
                  lane_rd[i]        = count[i][15:8];
                end else begin
                  read_high_next[i] = 1'b1;
                  lane_rd[i]        = count[i][7:0];
                end
              end
              default: lane_rd[i] = '0;
            endcase
          end
        end
        REQ_WRITE: begin
          if (data_hit) begin
            enabled_next[i] = 1'b1;
            case (mode)
              MODE_LSB: begin
                divider_next[i] = {8'd0, req.write_data};
                count_next[i]   = {8'd0, req.write_data};
                load            = 1'b1;
              end
              MODE_MSB: begin
                divider_next[i] = {req.write_data, 8'd0};
                count_next[i]   = {req.write_data, 8'd0};
                load            = 1'b1;
              end
              MODE_WORD: begin
                if (write_high[i]) begin
                  write_high_next[i] = 1'b0;
                  divider_next[i]    = {req.write_data, divider[i][7:0]};
                  count_next[i]      = {req.write_data, divider[i][7:0]};
                  load               = 1'b1;
                end else begin
                  write_high_next[i] = 1'b1;
                  divider_next[i]    = {divider[i][15:8], req.write_data};
                  count_next[i]      = {divider[i][15:8], req.write_data};
                end
              end
              default: ;
            endcase
          end else if (req.reg_select == REG_CONTROL) begin
            if (req.write_data[7:6] == SEL_READBACK) begin
              // read-back: bits 3:1 pick counters, bits 4 and 5 active low
              if (req.write_data[i + 1]) begin
                if (!req.write_data[4]) begin
                  stat_latch_next[i] = ctrl[i];
                  stat_valid_next[i] = 1'b1;
                end
                if (!req.write_data[5]) begin
                  cnt_snap_next[i]  = count[i];
                  cnt_valid_next[i] = 1'b1;
                end
              end
            end else if (req.write_data[7:6] == IDX) begin
              ctrl_next[i]       = req.write_data;
              enabled_next[i]    = 1'b0;
              write_high_next[i] = 1'b0;
              read_high_next[i]  = 1'b0;
              count_next[i]      = COUNT_FULL;
              divider_next[i]    = COUNT_FULL;
            end
          end
        end
        REQ_EXPIRY: begin
          if (sel_hit && enabled[i] && !req.inhibit[i]) begin
            if (IDX == CTR_SANITY) begin
              count_next[i] = COUNT_FULL;
              lane_nmi[i]   = 1'b1;
              lane_btirq[i] = 1'b1;
            end else if (IDX == CTR_INTERVAL) begin
              lane_clk[i] = 1'b1;
            end else if (mode == MODE_LSB) begin
              count_next[i] = COUNT_FULL;
              lane_btset[i] = 1'b1;
              lane_btirq[i] = 1'b1;
              lane_abort[i] = 1'b1;
            end
          end
        end
        REQ_START: begin
          if (sel_hit) load = 1'b1;
        end
        default: ;
      endcase

      // schedule request from the freshly loaded count
      if (load && !req.inhibit[i]) begin
        lane_start[i] = 1'b1;
        lane_delay[i] = count_next[i] - SUB;
        count_next[i] = count_next[i] - STEP;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctrl[i]       <= '0;
        divider[i]    <= '0;
        count[i]      <= '0;
        enabled[i]    <= 1'b0;
        write_high[i] <= 1'b0;
        read_high[i]  <= 1'b0;
        stat_valid[i] <= 1'b0;
        cnt_valid[i]  <= 1'b0;
        stat_latch[i] <= '0;
        cnt_snap[i]   <= '0;
      end else if (fire) begin
        ctrl[i]       <= ctrl_next[i];
        divider[i]    <= divider_next[i];
        count[i]      <= count_next[i];
        enabled[i]    <= enabled_next[i];
        write_high[i] <= write_high_next[i];
        read_high[i]  <= read_high_next[i];
        stat_valid[i] <= stat_valid_next[i];
        cnt_valid[i]  <= cnt_valid_next[i];
        stat_latch[i] <= stat_latch_next[i];
        cnt_snap[i]   <= cnt_snap_next[i];
      end
    end
  end

  // at most one lane is active, so the lanes merge by or
  always_comb begin
    res = '0;
    for (int n = 0; n < NUM_CTR; n++) begin
      res.read_data          = res.read_data | lane_rd[n];
      res.start_valid        = res.start_valid | lane_start[n];
      res.start_counter      = res.start_counter | (lane_start[n] ? 2'(n) : 2'd0);
      res.start_delay        = res.start_delay | lane_delay[n];
      res.nmi_raise          = res.nmi_raise | lane_nmi[n];
      res.sanity_timeout_set = res.sanity_timeout_set | lane_nmi[n];
      res.bus_timeout_set    = res.bus_timeout_set | lane_btset[n];
      res.bus_timeout_irq    = res.bus_timeout_irq | lane_btirq[n];
      res.bus_abort          = res.bus_abort | lane_abort[n];
    end
    res.stop_valid = (req.req_type == REQ_STOP) &&
                     (req.counter_sel != SEL_READBACK);
    if (lane_clk[CTR_INTERVAL]) begin
      res.clock_irq_action = CLK_SET;
    end else if (req.req_type == REQ_READ && req.reg_select == REG_CLR_CLK) begin
      res.clock_irq_action = CLK_CLEAR;
    end else begin
      res.clock_irq_action = CLK_NONE;
    end
  end

endmodule

// File: src/interval_timer_register_interface.sv
// path: input register, then result register, which drives the output ports
// throughput: one request per cycle while out_stall is low; the per-counter
//   state is updated in the single pass between the two registers, so the
//   next request sees it at once
// reset: synchronous, active high; all counter state and latches are cleared,
//   and both pipeline registers are marked empty
module interval_timer_register_interface (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [2:0]  reg_select,
  input  logic [7:0]  write_data,
  input  logic [1:0]  counter_sel,
  input  logic        sanity_inhibit,
  input  logic        interval_inhibit,
  input  logic        bus_timer_inhibit,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic        start_valid,
  output logic [1:0]  start_counter,
  output logic [15:0] start_delay,
  output logic        stop_valid,
  output logic        nmi_raise,
  output logic        sanity_timeout_set,
  output logic        bus_timeout_set,
  output logic        bus_timeout_irq,
  output logic [1:0]  clock_irq_action,
  output logic        bus_abort
);
  import itri_pkg::*;

  // input register
  req_t    req_q;
  logic    req_full;
  // result register
  result_t res_q;
  result_t res;
  logic    fire;

  // the held request is processed when the result register is free or emptying
  assign fire     = req_full && (!out_valid || !out_stall);
  assign in_stall = req_full && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
    end else if (!in_stall) begin
      req_full <= in_valid;
    end
  end

  // payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_q <= '{req_type:    req_type,
                 reg_select:  reg_select,
                 write_data:  write_data,
                 counter_sel: counter_sel,
                 inhibit:     {bus_timer_inhibit, interval_inhibit, sanity_inhibit}};
    end
  end

  // counter state and per-request decode
  itri_ctr_bank u_bank (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .req  (req_q),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign read_data          = res_q.read_data;
  assign start_valid        = res_q.start_valid;
  assign start_counter      = res_q.start_counter;
  assign start_delay        = res_q.start_delay;
  assign stop_valid         = res_q.stop_valid;
  assign nmi_raise          = res_q.nmi_raise;
  assign sanity_timeout_set = res_q.sanity_timeout_set;
  assign bus_timeout_set    = res_q.bus_timeout_set;
  assign bus_timeout_irq    = res_q.bus_timeout_irq;
  assign clock_irq_action   = res_q.clock_irq_action;
  assign bus_abort          = res_q.bus_abort;

  // a full input register with a stalled result must hold off new requests
  a_hold_off: assert property (@(posedge clk) disable iff (rst)
    (req_full && out_valid && out_stall) |-> in_stall)
    else $error("request taken while result stalled");

  // a processed request always shows up as a result in the next cycle
  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("processed request produced no result");

  // sanity expiry raises nmi together with its status and interrupt bits
  a_nmi_group: assert property (@(posedge clk) disable iff (rst)
    (out_valid && nmi_raise) |-> (sanity_timeout_set && bus_timeout_irq && !bus_abort))
    else $error("inconsistent sanity expiry result");

  // a start and a stop never come from the same request; clock action is never 3
  a_start_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(start_valid && stop_valid) && (clock_irq_action != 2'd3))
    else $error("conflicting result flags");

endmodule
